[rtl/ewts_pkg.sv]
package ewts_pkg;

    localparam int QueueDepth   = 16;
    localparam int TableEntries = 16;
    localparam int TaskBits     = 8;
    localparam int QCntW        = $clog2(QueueDepth + 1);

    typedef enum logic [1:0] {
        K_SUSPEND  = 2'd0,
        K_CANCEL   = 2'd1,
        K_SCHEDULE = 2'd2,
        K_NONE     = 2'd3
    } t_kind;

    localparam logic [2:0] EV_YIELD   = 3'd0;
    localparam logic [2:0] EV_STREAM  = 3'd1;
    localparam logic [2:0] EV_SUPDATE = 3'd2;
    localparam logic [2:0] EV_TIMER   = 3'd3;

    localparam logic [2:0] ST_RESUMED  = 3'd0;
    localparam logic [2:0] ST_SKIPPED  = 3'd1;
    localparam logic [2:0] ST_INVALID  = 3'd2;
    localparam logic [2:0] ST_ACCEPTED = 3'd3;
    localparam logic [2:0] ST_DROPPED  = 3'd4;

    localparam logic [0:0] ADDR_INVALID_DESC = 1'd0;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_FINISH,
        S_OUT
    } t_state;

    // Operation broadcast to the cells of one queue.
    typedef struct packed {
        logic                push;     // append at position count
        logic                pop;      // remove head
        logic                cancel;   // remove first match
        logic [QCntW-1:0]    count;
        logic [TaskBits-1:0] task_id;
    } t_qop;

    // Operation broadcast to the table cells.
    typedef struct packed {
        logic       insert;
        logic       remove;
        logic [63:0] key;
        logic [TaskBits-1:0] task_id;
    } t_top;

endpackage

[rtl/ewts_if.sv]
interface ewts_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [2:0]  event_kind;
    logic [7:0]  task_id;
    logic [63:0] descriptor;
    modport source (output valid, kind, event_kind, task_id, descriptor, input ready);
    modport sink (input valid, kind, event_kind, task_id, descriptor, output ready);
endinterface

interface ewts_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] resumed_task;
    modport source (output valid, status, resumed_task, input ready);
    modport sink (input valid, status, resumed_task, output ready);
endinterface

[rtl/ewts_qcell.sv]
// One FIFO slot. A match flag ripples from head to tail so that the slot
// at and behind the first match take their neighbor's word on removal.
module ewts_qcell (
    input  logic                             i_clk,
    input  logic [ewts_pkg::QCntW-1:0]       i_pos,
    input  logic                             i_apply,
    input  ewts_pkg::t_qop                   i_op,
    input  logic                             i_hit_in,
    input  logic [ewts_pkg::TaskBits-1:0]    i_next,
    output logic                             o_hit_out,
    output logic [ewts_pkg::TaskBits-1:0]    o_data
);
    logic [ewts_pkg::TaskBits-1:0] r_data;
    logic live, shift;

    assign live      = i_pos < i_op.count;
    assign o_hit_out = i_hit_in | (live & i_op.cancel & (r_data == i_op.task_id));
    assign shift     = i_op.pop | (i_op.cancel & o_hit_out);
    assign o_data    = r_data;

    always_ff @(posedge i_clk) begin
        if (i_apply) begin
            if (i_op.push && i_pos == i_op.count) begin
                r_data <= i_op.task_id;
            end else if (shift) begin
                r_data <= i_next;
            end
        end
    end
endmodule

[rtl/ewts_queue.sv]
module ewts_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_apply,
    input  ewts_pkg::t_qop                i_op,
    output logic [ewts_pkg::QCntW-1:0]    o_count,
    output logic [ewts_pkg::TaskBits-1:0] o_head
);
    localparam int N = ewts_pkg::QueueDepth;
    logic [N:0] hit;
    logic [ewts_pkg::TaskBits-1:0] data [N+1];
    logic [ewts_pkg::QCntW-1:0] r_count;

    assign hit[0]  = 1'b0;
    assign data[N] = '0;

    for (genvar g = 0; g < N; g++) begin : g_cell
        ewts_qcell u_cell (
            .i_clk    (i_clk),
            .i_pos    (ewts_pkg::QCntW'(g)),
            .i_apply  (i_apply),
            .i_op     (i_op),
            .i_hit_in (hit[g]),
            .i_next   (data[g+1]),
            .o_hit_out(hit[g+1]),
            .o_data   (data[g])
        );
    end

    assign o_head  = data[0];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_apply) begin
            if (i_op.push) begin
                r_count <= r_count + 1'b1;
            end else if (i_op.pop || (i_op.cancel && hit[N])) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

[rtl/ewts_tcell.sv]
// One wait-table slot: key compare, and a free flag plus a match flag
// that ripple down the row; an insert fills only the first free slot.
module ewts_tcell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_apply,
    input  ewts_pkg::t_top                i_op,
    input  logic                          i_free_in,
    input  logic                          i_hit_in,
    input  logic [ewts_pkg::TaskBits-1:0] i_task_in,
    output logic                          o_free_out,
    output logic                          o_hit_out,
    output logic [ewts_pkg::TaskBits-1:0] o_task_out
);
    logic                          r_valid;
    logic [63:0]                   r_key;
    logic [ewts_pkg::TaskBits-1:0] r_task;
    logic match, first_free;

    assign match      = r_valid & (r_key == i_op.key);
    assign first_free = ~r_valid & ~i_free_in;
    assign o_free_out = i_free_in | ~r_valid;
    assign o_hit_out  = i_hit_in | match;
    assign o_task_out = match ? r_task : i_task_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_apply) begin
            if (i_op.insert && first_free) begin
                r_valid <= 1'b1;
            end else if (i_op.remove && match) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_apply && i_op.insert && first_free) begin
            r_key  <= i_op.key;
            r_task <= i_op.task_id;
        end
    end
endmodule

[rtl/event_wait_task_scheduler_top.sv]
// Wait-queue scheduler: two FIFOs and a keyed wait table, each a row of cells.
// A word is held, searched in S_SWEEP, committed in S_FINISH and shown in
// S_OUT; a new word is taken only once the result has been taken, so
// holding off the output also holds off the input.
// Reset (i_rst_n low, synchronous): queues empty, table entries invalid,
// invalid_descriptor all ones.
module event_wait_task_scheduler_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ewts_in_if.sink     in_w,
    ewts_out_if.source  out_w,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    localparam int TB = ewts_pkg::TaskBits;
    localparam int TN = ewts_pkg::TableEntries;

    ewts_pkg::t_state r_state, n_state;

    logic [63:0]   r_inv;
    logic [1:0]    r_kind;
    logic [2:0]    r_ev;
    logic [TB-1:0] r_task;
    logic [63:0]   r_desc;
    logic [2:0]    r_status;
    logic [TB-1:0] r_res;

    // Register file: one register, decoded from paddr[2] low (byte addresses zero to three).
    assign pready = 1'b1;
    assign prdata = (paddr[2] == ewts_pkg::ADDR_INVALID_DESC) ? r_inv : 64'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv <= '1;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == ewts_pkg::ADDR_INVALID_DESC) begin
            r_inv <= pwdata;
        end
    end

    // Decode the held word.
    logic is_susp, is_canc, is_sched, ev_y, ev_s, ev_t, desc_bad;
    assign is_susp  = r_kind == ewts_pkg::K_SUSPEND;
    assign is_canc  = r_kind == ewts_pkg::K_CANCEL;
    assign is_sched = r_kind == ewts_pkg::K_SCHEDULE;
    assign ev_y     = r_ev == ewts_pkg::EV_YIELD;
    assign ev_s     = r_ev == ewts_pkg::EV_STREAM;
    assign ev_t     = r_ev == ewts_pkg::EV_SUPDATE || r_ev == ewts_pkg::EV_TIMER;
    assign desc_bad = r_desc == r_inv;

    // Search results of the rows; the table outcome is sampled in S_SWEEP.
    logic [ewts_pkg::QCntW-1:0] ycnt, scnt;
    logic [TB-1:0] yhead, shead;
    logic [TN:0] tfree, thit;
    logic [TB-1:0] ttask [TN+1];
    logic r_tfree, r_thit;
    logic [TB-1:0] r_ttask;

    logic apply;
    assign apply = r_state == ewts_pkg::S_FINISH;

    ewts_pkg::t_qop yop, sop;
    ewts_pkg::t_top top;
    logic yfull, sfull;
    assign yfull = ycnt == ewts_pkg::QCntW'(ewts_pkg::QueueDepth);
    assign sfull = scnt == ewts_pkg::QCntW'(ewts_pkg::QueueDepth);

    always_comb begin
        yop.push    = is_susp & ev_y & ~yfull;
        yop.pop     = is_sched & ev_y & (ycnt != '0);
        yop.cancel  = is_canc & ev_y;
        yop.count   = ycnt;
        yop.task_id = r_task;
        sop.push    = is_susp & ev_s & ~sfull;
        sop.pop     = is_sched & ev_s & (scnt != '0);
        sop.cancel  = is_canc & ev_s;
        sop.count   = scnt;
        sop.task_id = r_task;
        top.insert  = is_susp & ev_t & ~desc_bad & ~r_thit;
        top.remove  = (is_canc & ev_t) | (is_sched & ev_t & ~desc_bad);
        top.key     = r_desc;
        top.task_id = r_task;
    end

    ewts_queue u_yq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_apply(apply), .i_op(yop),
        .o_count(ycnt), .o_head(yhead)
    );
    ewts_queue u_sq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_apply(apply), .i_op(sop),
        .o_count(scnt), .o_head(shead)
    );

    assign tfree[0] = 1'b0;
    assign thit[0]  = 1'b0;
    assign ttask[0] = '0;
    for (genvar g = 0; g < TN; g++) begin : g_tab
        ewts_tcell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_apply(apply), .i_op(top),
            .i_free_in(tfree[g]), .i_hit_in(thit[g]), .i_task_in(ttask[g]),
            .o_free_out(tfree[g+1]), .o_hit_out(thit[g+1]), .o_task_out(ttask[g+1])
        );
    end

    // Hold the table search outcome before the commit cycle.
    always_ff @(posedge i_clk) begin
        if (r_state == ewts_pkg::S_SWEEP) begin
            r_tfree <= tfree[TN];
            r_thit  <= thit[TN];
            r_ttask <= ttask[TN];
        end
    end

    // Result of the held word, formed in the commit cycle.
    logic [2:0]    res_st;
    logic [TB-1:0] res_tk;
    always_comb begin
        res_st = ewts_pkg::ST_DROPPED;
        res_tk = '0;
        unique case (r_kind)
            ewts_pkg::K_SUSPEND: begin
                if (ev_y) begin
                    res_st = yfull ? ewts_pkg::ST_DROPPED : ewts_pkg::ST_ACCEPTED;
                end else if (ev_s) begin
                    res_st = sfull ? ewts_pkg::ST_DROPPED : ewts_pkg::ST_ACCEPTED;
                end else if (ev_t) begin
                    res_st = (desc_bad || r_thit || !r_tfree) ? ewts_pkg::ST_DROPPED
                                                              : ewts_pkg::ST_ACCEPTED;
                end
            end
            ewts_pkg::K_CANCEL: begin
                if (ev_y || ev_s || ev_t) res_st = ewts_pkg::ST_ACCEPTED;
            end
            ewts_pkg::K_SCHEDULE: begin
                res_st = ewts_pkg::ST_SKIPPED;
                if (ev_y && ycnt != '0) begin
                    res_st = ewts_pkg::ST_RESUMED;
                    res_tk = yhead;
                end else if (ev_s && scnt != '0) begin
                    res_st = ewts_pkg::ST_RESUMED;
                    res_tk = shead;
                end else if (ev_t && desc_bad) begin
                    res_st = ewts_pkg::ST_INVALID;
                end else if (ev_t && r_thit) begin
                    res_st = ewts_pkg::ST_RESUMED;
                    res_tk = r_ttask;
                end
            end
            default: res_st = ewts_pkg::ST_DROPPED;
        endcase
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ewts_pkg::S_IDLE:   if (in_w.valid) n_state = ewts_pkg::S_SWEEP;
            ewts_pkg::S_SWEEP:  n_state = ewts_pkg::S_FINISH;
            ewts_pkg::S_FINISH: n_state = ewts_pkg::S_OUT;
            ewts_pkg::S_OUT:    if (out_w.ready) n_state = ewts_pkg::S_IDLE;
            default:            n_state = ewts_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        in_w.ready   = r_state == ewts_pkg::S_IDLE;
        out_w.valid  = r_state == ewts_pkg::S_OUT;
        out_w.status = r_status;
        out_w.resumed_task = 8'(r_res);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ewts_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_w.valid && in_w.ready) begin
            r_kind <= in_w.kind;
            r_ev   <= in_w.event_kind;
            r_task <= TB'(in_w.task_id);
            r_desc <= in_w.descriptor;
        end
        if (apply) begin
            r_status <= res_st;
            r_res    <= res_tk;
        end
    end

`ifndef SYNTH
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_w.valid && in_w.ready) |=> !in_w.ready)
        else $error("second word taken while busy");
    a_out_after_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(out_w.valid) |-> $past(r_state == ewts_pkg::S_FINISH))
        else $error("result without commit");
    a_resumed_tk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_w.valid && out_w.status != ewts_pkg::ST_RESUMED) |-> out_w.resumed_task == 8'd0)
        else $error("task reported without resume");
    a_ycnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ycnt <= ewts_pkg::QCntW'(ewts_pkg::QueueDepth))
        else $error("yield count overflow");
`endif
endmodule
